FILE: hdl/jse_pkg.sv
// shared types, character codes and byte-selection functions of the escape encoder
package jse_pkg;

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;

  // control codes with a short escape
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_HT = 8'h09;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_VT = 8'h0B;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_CR = 8'h0D;

  // first byte that is no longer a control code
  localparam logic [7:0] CTL_LIMIT = 8'h20;

  // body lengths: none for an empty body, and one for each of the three body kinds
  localparam logic [2:0] LEN_NONE    = 3'd0;
  localparam logic [2:0] LEN_PLAIN   = 3'd1;
  localparam logic [2:0] LEN_SHORT   = 3'd2;
  localparam logic [2:0] LEN_UNICODE = 3'd6;

  // how the body of one request is written out
  typedef enum logic [1:0] {
    BODY_PLAIN,
    BODY_SHORT,
    BODY_UNICODE
  } body_kind_t;

  // one classified request, as queued between front and back
  typedef struct packed {
    logic       has_open;
    logic       has_close;
    body_kind_t kind;
    logic [2:0] body_len;
    logic [2:0] last_idx;
    logic [7:0] data;
  } job_t;

  // lower-case hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    if (nib < 4'd10) begin
      hex_digit = CH_ZERO + wide;
    end else begin
      hex_digit = CH_LC_A + wide - 8'd10;
    end
  endfunction

  // byte at position j of the body
  function automatic logic [7:0] body_byte(input body_kind_t kind, input logic [7:0] data,
                                           input logic [2:0] j);
    body_byte = data;
    case (kind)
      BODY_PLAIN: begin
        body_byte = data;
      end
      BODY_SHORT: begin
        body_byte = (j == 3'd0) ? CH_BSLASH : data;
      end
      BODY_UNICODE: begin
        case (j)
          3'd0: body_byte = CH_BSLASH;
          3'd1: body_byte = CH_U;
          3'd2: body_byte = CH_ZERO;
          3'd3: body_byte = CH_ZERO;
          3'd4: body_byte = hex_digit(data[7:4]);
          default: body_byte = hex_digit(data[3:0]);
        endcase
      end
      default: begin
        body_byte = data;
      end
    endcase
  endfunction

  // byte at position k of the whole run of a request
  function automatic logic [7:0] job_byte(input job_t job, input logic [2:0] k);
    logic [2:0] j;
    j = k - {2'd0, job.has_open};
    if (job.has_open && (k == 3'd0)) begin
      job_byte = CH_QUOTE;
    end else if (j < job.body_len) begin
      job_byte = body_byte(job.kind, job.data, j);
    end else begin
      job_byte = CH_QUOTE;
    end
  endfunction

endpackage

FILE: hdl/jse_if.sv
// valid/ready channel interfaces for the raw byte input and the escaped byte output

// raw string bytes with their framing flags
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_first;
  logic       is_last;
  logic       is_empty;

  modport source (output valid, output char_byte, output is_first, output is_last,
                  output is_empty, input ready);
  modport sink (input valid, input char_byte, input is_first, input is_last,
                input is_empty, output ready);
endinterface

// escaped, quoted output bytes
interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  modport source (output valid, output out_byte, output run_last, output string_done,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_done,
                output ready);
endinterface

FILE: hdl/jse_front.sv
// front part: takes input requests and classifies each into a queued job
module jse_front (
  jse_in_if.sink       in_chan,
  input  logic         q_full,
  output logic         push,
  output jse_pkg::job_t job
);
  import jse_pkg::*;

  logic [7:0] letter;
  logic       is_ctl;
  logic [3:0] total;

  // ready as long as the queue has room
  assign in_chan.ready = !q_full;

  // short escape letter, zero when the byte has none
  always_comb begin
    case (in_chan.char_byte)
      CTL_BS:    letter = CH_LC_B;
      CTL_FF:    letter = CH_LC_F;
      CTL_LF:    letter = CH_LC_N;
      CTL_CR:    letter = CH_LC_R;
      CTL_HT:    letter = CH_LC_T;
      CTL_VT:    letter = CH_LC_V;
      CH_QUOTE:  letter = CH_QUOTE;
      CH_BSLASH: letter = CH_BSLASH;
      default:   letter = 8'd0;
    endcase
  end

  assign is_ctl = (in_chan.char_byte != 8'd0) && (in_chan.char_byte < CTL_LIMIT);

  // body kind and length
  always_comb begin
    job.has_open  = in_chan.is_first;
    job.has_close = in_chan.is_last;
    job.kind      = BODY_PLAIN;
    job.body_len  = LEN_PLAIN;
    job.data      = in_chan.char_byte;
    if (in_chan.is_empty) begin
      job.body_len = LEN_NONE;
    end else if (letter != 8'd0) begin
      job.kind     = BODY_SHORT;
      job.body_len = LEN_SHORT;
      job.data     = letter;
    end else if (is_ctl) begin
      job.kind     = BODY_UNICODE;
      job.body_len = LEN_UNICODE;
    end
    total        = {3'd0, in_chan.is_first} + {1'b0, job.body_len} + {3'd0, in_chan.is_last};
    job.last_idx = 3'(total - 4'd1);
  end

  // requests that give no output are taken and dropped
  assign push = in_chan.valid && in_chan.ready && (total != 4'd0);

endmodule

FILE: hdl/jse_queue.sv
// short job queue between the front and back parts
module jse_queue #(
  parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jse_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output jse_pkg::job_t head,
  output logic          empty
);
  import jse_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/jse_back.sv
// back part: walks each queued job and emits one byte per cycle through an output register while out_chan is ready
module jse_back (
  input  logic          clk,
  input  logic          rst,
  input  jse_pkg::job_t head,
  input  logic          q_empty,
  output logic          pop,
  jse_out_if.source     out_chan
);
  import jse_pkg::*;

  logic [2:0] pos;
  logic       valid;
  logic [7:0] byte_reg;
  logic       last_reg;
  logic       done_reg;
  logic       load;
  logic       advance;
  logic       at_end;

  // output register takes a new byte when empty or being drained
  assign load    = !valid || out_chan.ready;
  assign advance = load && !q_empty;
  assign at_end  = (pos == head.last_idx);
  assign pop     = advance && at_end;

  // position within the current job and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      valid <= 1'b0;
    end else begin
      if (advance) begin
        pos <= at_end ? 3'd0 : pos + 3'd1;
      end
      if (load) begin
        valid <= !q_empty;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      byte_reg <= job_byte(head, pos);
      last_reg <= at_end;
      done_reg <= at_end && head.has_close;
    end
  end

  assign out_chan.valid       = valid;
  assign out_chan.out_byte    = byte_reg;
  assign out_chan.run_last    = last_reg;
  assign out_chan.string_done = done_reg;

endmodule

FILE: hdl/json_string_escape_encoder.sv
// top level of the JSON string escape encoder
//
// in_chan takes one raw string byte per request with is_first, is_last and
// is_empty flags; out_chan gives the quoted, escaped text one byte per transfer.
// is_first puts an opening quote before the byte's output, is_last a closing
// quote (string_done set) after it; run_last marks each request's final byte.
// A request with is_empty and no flags gives no output and is dropped.
// With the back part idle, the first byte of a request is written into the job
// queue and then into the output register before it shows.
// Throughput: one output byte per cycle through the single output register,
// while out_chan is ready; a request gives 1 to 8 bytes (quote, escape of up
// to six bytes, quote). Input requests are taken every cycle while the job
// queue (QUEUE_DEPTH entries) has room, so short escapes of later bytes queue
// up while a long escape is still being written out.
// When out_chan stalls, the output byte holds, the queue fills and then
// in_chan.ready drops. Reset empties the queue and the output register.
module json_string_escape_encoder #(
  parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  jse_in_if.sink     in_chan,
  jse_out_if.source  out_chan
);
  import jse_pkg::*;

  job_t front_job;
  job_t head_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  // classify requests
  jse_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push),
    .job     (front_job)
  );

  // decouple front and back
  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (front_job),
    .full   (q_full),
    .pop    (pop),
    .head   (head_job),
    .empty  (q_empty)
  );

  // emit bytes
  jse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head_job),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

FILE: hdl/jse_checker.sv
// port-level checks of the escape encoder and their binding to the top level
module jse_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_first,
  input logic       in_last,
  input logic       in_empty,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       string_done
);
  import jse_pkg::*;

  logic [7:0] pending;
  logic       in_take;
  logic       out_end;

  assign in_take = in_valid && in_ready && (in_first || in_last || !in_empty);
  assign out_end = out_valid && out_ready && run_last;

  // requests taken whose final byte has not gone out yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {7'd0, in_take} - {7'd0, out_end};
    end
  end

  // stalled output holds its byte
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
      && $stable(string_done))
    else $error("stalled output changed");

  // closing quote ends its request
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> run_last && (out_byte == CH_QUOTE))
    else $error("string_done not on a final quote");

  // a request's final byte only for a request taken earlier
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_end |-> pending != 8'd0)
    else $error("final byte without a pending request");

  // nothing shown right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind json_string_escape_encoder jse_checker u_jse_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_first    (in_chan.is_first),
  .in_last     (in_chan.is_last),
  .in_empty    (in_chan.is_empty),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_byte    (out_chan.out_byte),
  .run_last    (out_chan.run_last),
  .string_done (out_chan.string_done)
);

FILE: bench/json_string_escape_encoder_tb.sv
// self-checking testbench of the JSON string escape encoder
`timescale 1ns / 100ps

module json_string_escape_encoder_tb;
  import jse_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 86;
  localparam int LONG_HOLD_CYCLES = 100;
  localparam int TAIL_CYCLES = 20;

  // one byte of quoted text as the block should emit it
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } esc_byte_t;

  // expected escaped text, built per request and consumed per output byte
  class escape_scoreboard;
    esc_byte_t quoted_text[$];
    int        mismatches;
    int        requests_noted;
    int        bytes_checked;

    function new();
      mismatches = 0;
      requests_noted = 0;
      bytes_checked = 0;
    endfunction

    function logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
        return CH_ZERO + {4'd0, nib};
      end
      return CH_LC_A + {4'd0, nib} - 8'd10;
    endfunction

    function void add_byte(input logic [7:0] b, input logic closing);
      esc_byte_t rec;
      rec.out_byte = b;
      rec.run_last = 1'b0;
      rec.string_done = closing;
      quoted_text = {quoted_text, rec};
    endfunction

    // expand one accepted request into its output bytes
    function void note_request(input logic [7:0] c, input logic first, input logic last,
                               input logic empty);
      int         start;
      logic [7:0] letter;
      start = quoted_text.size();
      letter = 8'h00;
      requests_noted++;
      if (first) begin
        add_byte(CH_QUOTE, 1'b0);
      end
      if (!empty) begin
        case (c)
          CTL_BS:    letter = CH_LC_B;
          CTL_FF:    letter = CH_LC_F;
          CTL_LF:    letter = CH_LC_N;
          CTL_CR:    letter = CH_LC_R;
          CTL_HT:    letter = CH_LC_T;
          CTL_VT:    letter = CH_LC_V;
          CH_QUOTE:  letter = CH_QUOTE;
          CH_BSLASH: letter = CH_BSLASH;
          default:   letter = 8'h00;
        endcase
        if (letter != 8'h00) begin
          add_byte(CH_BSLASH, 1'b0);
          add_byte(letter, 1'b0);
        end else if (c >= 8'd1 && c < CTL_LIMIT) begin
          add_byte(CH_BSLASH, 1'b0);
          add_byte(CH_U, 1'b0);
          add_byte(CH_ZERO, 1'b0);
          add_byte(CH_ZERO, 1'b0);
          add_byte(hex_char(c[7:4]), 1'b0);
          add_byte(hex_char(c[3:0]), 1'b0);
        end else begin
          add_byte(c, 1'b0);
        end
      end
      if (last) begin
        add_byte(CH_QUOTE, 1'b1);
      end
      if (quoted_text.size() > start) begin
        quoted_text[quoted_text.size() - 1].run_last = 1'b1;
      end
    endfunction

    function void report(input string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: %s", what);
      end
    endfunction

    // compare one output byte with the oldest expectation
    function void check_byte(input esc_byte_t got);
      esc_byte_t want;
      bytes_checked++;
      if (quoted_text.size() == 0) begin
        report($sformatf("unexpected byte %h run_last %b string_done %b",
                         got.out_byte, got.run_last, got.string_done));
      end else begin
        want = quoted_text.pop_front();
        if (got.out_byte !== want.out_byte) begin
          report($sformatf("out_byte exp %h got %h", want.out_byte, got.out_byte));
        end
        if (got.run_last !== want.run_last) begin
          report($sformatf("run_last exp %b got %b (byte %h)", want.run_last,
                           got.run_last, want.out_byte));
        end
        if (got.string_done !== want.string_done) begin
          report($sformatf("string_done exp %b got %b (byte %h)", want.string_done,
                           got.string_done, want.out_byte));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  jse_in_if  in_chan ();
  jse_out_if out_chan ();

  json_string_escape_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  escape_scoreboard sb = new();

  int         burst_left;
  int         idle_cycles = 0;
  int         strings_sent;
  logic       long_hold_req;
  logic       long_hold_done;
  logic [7:0] str_buf [0:15];

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver: stall pattern that switches among four modes, plus one long hold
  initial begin : receiver
    int hold_left;
    int cyc;
    int mode;
    hold_left = 0;
    cyc = 0;
    mode = 0;
    out_chan.ready = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) begin
        mode = $urandom_range(0, 3);
      end
      if (long_hold_req && !long_hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready = 1'b0;
      end else begin
        case (mode)
          0: out_chan.ready = 1'b1;
          1: out_chan.ready = ($urandom_range(0, 1) == 1);
          2: out_chan.ready = (cyc % 3 != 0);
          default: out_chan.ready = ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // monitor both channels, feed the scoreboard, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_chan.valid && in_chan.ready) begin
        sb.note_request(in_chan.char_byte, in_chan.is_first, in_chan.is_last,
                        in_chan.is_empty);
      end
      if (out_chan.valid && out_chan.ready) begin
        sb.check_byte({out_chan.out_byte, out_chan.run_last, out_chan.string_done});
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("json_string_escape_encoder_tb NOT OK");
        $finish;
      end
    end
  end

  // offer one request; sender works in bursts with random gaps between them
  task automatic send_request(input logic [7:0] c, input logic first, input logic last,
                              input logic empty);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        in_chan.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_chan.valid = 1'b1;
    in_chan.char_byte = c;
    in_chan.is_first = first;
    in_chan.is_last = last;
    in_chan.is_empty = empty;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // send str_buf[0 .. len-1] as one framed string; len 0 is the empty string
  task automatic send_string(input int len);
    if (len == 0) begin
      send_request(8'($urandom), 1'b1, 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < len; i++) begin
        send_request(str_buf[i], i == 0, i == len - 1, 1'b0);
      end
    end
    strings_sent++;
  endtask

  // byte mix weighted toward the interesting classes
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(32, 126));
      4: return 8'($urandom_range(0, 31));
      5: return 8'($urandom_range(128, 255));
      6: return CH_QUOTE;
      7: return CH_BSLASH;
      8: return 8'($urandom);
      default: return 8'($urandom_range(CTL_BS, CTL_CR));
    endcase
  endfunction

  // stimulus and end of run
  initial begin : stimulus
    int random_sent;
    int len;
    logic [7:0] c;
    logic f, l, e;
    random_sent = 0;
    burst_left = 0;
    strings_sent = 0;
    long_hold_req = 1'b0;
    rst = 1'b1;
    in_chan.valid = 1'b0;
    in_chan.char_byte = 8'h00;
    in_chan.is_first = 1'b0;
    in_chan.is_last = 1'b0;
    in_chan.is_empty = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty string: just the two quotes
    send_request(8'hA5, 1'b1, 1'b1, 1'b1);
    // plain byte, quote and backslash
    str_buf[0] = 8'h61;
    str_buf[1] = CH_QUOTE;
    str_buf[2] = CH_BSLASH;
    send_string(3);
    // every short control escape
    str_buf[0] = CTL_BS;
    str_buf[1] = CTL_FF;
    str_buf[2] = CTL_LF;
    str_buf[3] = CTL_CR;
    str_buf[4] = CTL_HT;
    str_buf[5] = CTL_VT;
    send_string(6);
    // nul, unicode escapes, boundaries and high bytes
    str_buf[0] = 8'h00;
    str_buf[1] = 8'h01;
    str_buf[2] = 8'h1F;
    str_buf[3] = 8'h10;
    str_buf[4] = 8'h1A;
    str_buf[5] = 8'h20;
    str_buf[6] = 8'h7F;
    str_buf[7] = 8'h80;
    str_buf[8] = 8'hFF;
    send_string(9);
    // longest run: quote, six-byte escape, quote
    send_request(8'h01, 1'b1, 1'b1, 1'b0);
    // empty with only one flag, empty with none, bare byte without quotes
    send_request(8'h5A, 1'b1, 1'b0, 1'b1);
    send_request(8'h3C, 1'b0, 1'b1, 1'b1);
    send_request(8'hC3, 1'b0, 1'b0, 1'b1);
    send_request(8'h41, 1'b0, 1'b0, 1'b0);

    // random part; the receiver holds off at the start so the block fills up
    long_hold_req = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any flags, any byte
        c = 8'($urandom);
        f = 1'($urandom);
        l = 1'($urandom);
        e = 1'($urandom);
        send_request(c, f, l, e);
        if (!(e && !f && !l)) begin
          random_sent++;
        end
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          str_buf[i] = pick_char();
        end
        send_string(len);
        random_sent += (len == 0) ? 1 : len;
      end
    end
    @(negedge clk);
    in_chan.valid = 1'b0;

    // drain
    while (sb.quoted_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.quoted_text.size() != 0) begin
      sb.report($sformatf("%0d expected bytes never arrived", sb.quoted_text.size()));
    end
    if (sb.mismatches > 10) begin
      $display("%0d further mismatches not shown", sb.mismatches - 10);
    end
    $display("covered %0d requests in %0d framed strings plus flag noise, %0d output bytes",
             sb.requests_noted, strings_sent, sb.bytes_checked);
    $display("output held off for %0d cycles once while input kept coming, %0d mismatches",
             LONG_HOLD_CYCLES, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("json_string_escape_encoder_tb OK");
    end else begin
      $display("json_string_escape_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/jse_pkg.sv
hdl/jse_if.sv
hdl/jse_front.sv
hdl/jse_queue.sv
hdl/jse_back.sv
hdl/json_string_escape_encoder.sv
hdl/jse_checker.sv
bench/json_string_escape_encoder_tb.sv
